>>> sv/color_key_alpha_setter_unit_macros.svh
// color_key_alpha_setter_unit_macros.svh: assertion macros for the colour key unit
// depends on: nothing; the including module provides clk and rst_n
`ifndef COLOR_KEY_ALPHA_SETTER_UNIT_MACROS_SVH
`define COLOR_KEY_ALPHA_SETTER_UNIT_MACROS_SVH

// property holds in the same cycle as its trigger
`define CKAS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("colour key unit: assertion failed");

// property holds in the cycle after its trigger
`define CKAS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("colour key unit: assertion failed");

`endif

>>> sv/ckas_pkg.sv
// ckas_pkg: types, register indexes and constants of the colour key alpha unit
// depends on: nothing
package ckas_pkg;

    // coordinate, selection edge, configuration, limit and distance widths
    localparam int COORD_BITS    = 12;
    localparam int EDGE_BITS     = COORD_BITS + 1;
    localparam int CFG_DATA_BITS = 24;
    localparam int CFG_IDX_BITS  = 3;
    localparam int LIMIT_BITS    = 16;
    localparam int DIST_BITS     = 18;

    // mode flag bit positions
    localparam int MODE_ANY_COLOUR = 0;
    localparam int MODE_HAS_ALPHA  = 1;

    // register reset values
    localparam logic [23:0]          KEY_COLOR_RESET = 24'hFF_FFFF;
    localparam logic [7:0]           ALPHA_RESET     = 8'hFF;
    localparam logic [EDGE_BITS-1:0] SEL_MAX_RESET   = EDGE_BITS'(4096);

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_KEY_COLOR   = 3'd0,
        REG_ALPHA_VALUE = 3'd1,
        REG_TOLERANCE   = 3'd2,
        REG_MODE_FLAGS  = 3'd3,
        REG_SEL_MIN_X   = 3'd4,
        REG_SEL_MAX_X   = 3'd5,
        REG_SEL_MIN_Y   = 3'd6,
        REG_SEL_MAX_Y   = 3'd7
    } cfg_index_t;

    // input pixel transfer
    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [7:0]            in_red;
        logic [7:0]            in_green;
        logic [7:0]            in_blue;
        logic [7:0]            in_alpha;
    } pixel_t;

    // result pixel transfer
    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } result_t;

    // configuration as seen by the match logic
    typedef struct packed {
        logic [23:0]           key_color;
        logic [LIMIT_BITS-1:0] limit;
        logic [1:0]            mode_flags;
        logic [EDGE_BITS-1:0]  sel_min_x;
        logic [EDGE_BITS-1:0]  sel_max_x;
        logic [EDGE_BITS-1:0]  sel_min_y;
        logic [EDGE_BITS-1:0]  sel_max_y;
    } cfg_t;

endpackage

>>> sv/ckas_match.sv
// ckas_match: key distance and selection test for one registered pixel
// depends on: ckas_pkg
module ckas_match (
    input  ckas_pkg::pixel_t pixel,
    input  ckas_pkg::cfg_t   cfg,
    output logic             hit
);

    logic [7:0]                    diff_r;
    logic [7:0]                    diff_g;
    logic [7:0]                    diff_b;
    logic [15:0]                   sq_r;
    logic [15:0]                   sq_g;
    logic [15:0]                   sq_b;
    logic [ckas_pkg::DIST_BITS-1:0] key_dist;
    logic                          in_sel;
    logic                          colour_ok;
    logic [7:0]                    key_r;
    logic [7:0]                    key_g;
    logic [7:0]                    key_b;

    assign key_r = cfg.key_color[23:16];
    assign key_g = cfg.key_color[15:8];
    assign key_b = cfg.key_color[7:0];

    // absolute channel differences
    assign diff_r = (pixel.in_red   > key_r) ? pixel.in_red   - key_r : key_r - pixel.in_red;
    assign diff_g = (pixel.in_green > key_g) ? pixel.in_green - key_g : key_g - pixel.in_green;
    assign diff_b = (pixel.in_blue  > key_b) ? pixel.in_blue  - key_b : key_b - pixel.in_blue;

    // squared distance, three narrow squares in parallel
    assign sq_r = diff_r * diff_r;
    assign sq_g = diff_g * diff_g;
    assign sq_b = diff_b * diff_b;
    assign key_dist = ckas_pkg::DIST_BITS'(sq_r) + ckas_pkg::DIST_BITS'(sq_g)
                    + ckas_pkg::DIST_BITS'(sq_b);

    // half-open selection rectangle
    assign in_sel = ({1'b0, pixel.pixel_x} >= cfg.sel_min_x)
                 && ({1'b0, pixel.pixel_x} <  cfg.sel_max_x)
                 && ({1'b0, pixel.pixel_y} >= cfg.sel_min_y)
                 && ({1'b0, pixel.pixel_y} <  cfg.sel_max_y);

    assign colour_ok = cfg.mode_flags[ckas_pkg::MODE_ANY_COLOUR]
                    || (key_dist <= ckas_pkg::DIST_BITS'(cfg.limit));

    assign hit = in_sel && colour_ok;

endmodule

>>> sv/color_key_alpha_setter_unit.sv
// color_key_alpha_setter_unit: colour key alpha setter, top level
// depends on: ckas_pkg, ckas_match, color_key_alpha_setter_unit_macros.svh
//
// Usage
//   Pixel channel: a pixel transfer happens at a rising edge with start high
//   and busy low. busy is never raised, so a pixel may be offered every cycle.
//   Result channel: done is high for exactly one cycle with the result pixel on
//   result; the receiver takes it at the edge that ends that cycle and cannot
//   stall the unit, so no back-pressure exists.
//   Path: a pixel taken at an edge is held in the pixel register, then its result
//   in the result register, shown with done high. Throughput: one pixel per cycle,
//   set by the two-register path (pixel register, match logic, result register).
//   Configuration: wr_en, wr_index and wr_data write one register per edge;
//   write only while no pixel is in flight. Tolerance is squared on write.
//   Reset: rst_n low clears the pipeline valids, dropping any pixel in flight,
//   and returns every configuration register to its reset value (white key, alpha 255,
//   tolerance 0, modes off, selection covering the whole frame).
//   RGB passes unchanged; alpha becomes the key alpha on a match inside the
//   selection, else the source alpha or zero.
`include "color_key_alpha_setter_unit_macros.svh"

module color_key_alpha_setter_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // pixel channel
    input  logic                                start,
    output logic                                busy,
    input  ckas_pkg::pixel_t                    pixel,
    // result channel
    output logic                                done,
    output ckas_pkg::result_t                   result,
    // configuration write port
    input  logic                                wr_en,
    input  logic [ckas_pkg::CFG_IDX_BITS-1:0]   wr_index,
    input  logic [ckas_pkg::CFG_DATA_BITS-1:0]  wr_data
);

    ckas_pkg::cfg_t    cfg_reg;
    ckas_pkg::cfg_t    cfg_next;
    logic [7:0]        alpha_value_reg;
    logic [7:0]        alpha_value_next;
    ckas_pkg::pixel_t  pixel_reg;
    logic              stage_valid_reg;
    ckas_pkg::result_t result_reg;
    ckas_pkg::result_t result_next;
    logic              done_reg;
    logic              hit;
    logic              take;

    // the pipeline takes a pixel every cycle
    assign busy = 1'b0;
    assign take = start && !busy;

    // configuration register writes
    always_comb
    begin
        cfg_next         = cfg_reg;
        alpha_value_next = alpha_value_reg;
        if (wr_en)
        begin
            case (ckas_pkg::cfg_index_t'(wr_index))
                ckas_pkg::REG_KEY_COLOR:   cfg_next.key_color  = wr_data[23:0];
                ckas_pkg::REG_ALPHA_VALUE: alpha_value_next    = wr_data[7:0];
                ckas_pkg::REG_TOLERANCE:   cfg_next.limit      = wr_data[7:0] * wr_data[7:0];
                ckas_pkg::REG_MODE_FLAGS:  cfg_next.mode_flags = wr_data[1:0];
                ckas_pkg::REG_SEL_MIN_X:
                    cfg_next.sel_min_x = wr_data[ckas_pkg::EDGE_BITS-1:0];
                ckas_pkg::REG_SEL_MAX_X:
                    cfg_next.sel_max_x = wr_data[ckas_pkg::EDGE_BITS-1:0];
                ckas_pkg::REG_SEL_MIN_Y:
                    cfg_next.sel_min_y = wr_data[ckas_pkg::EDGE_BITS-1:0];
                ckas_pkg::REG_SEL_MAX_Y:
                    cfg_next.sel_max_y = wr_data[ckas_pkg::EDGE_BITS-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_color  <= ckas_pkg::KEY_COLOR_RESET;
            cfg_reg.limit      <= '0;
            cfg_reg.mode_flags <= '0;
            cfg_reg.sel_min_x  <= '0;
            cfg_reg.sel_max_x  <= ckas_pkg::SEL_MAX_RESET;
            cfg_reg.sel_min_y  <= '0;
            cfg_reg.sel_max_y  <= ckas_pkg::SEL_MAX_RESET;
            alpha_value_reg    <= ckas_pkg::ALPHA_RESET;
        end
        else
        begin
            cfg_reg         <= cfg_next;
            alpha_value_reg <= alpha_value_next;
        end
    end

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= take;
            done_reg        <= stage_valid_reg;
        end
    end

    // pixel register, loaded on each transfer
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pixel_reg <= pixel;
        end
    end

    ckas_match u_match (
        .pixel (pixel_reg),
        .cfg   (cfg_reg),
        .hit   (hit)
    );

    // alpha selection
    always_comb
    begin
        result_next.out_red   = pixel_reg.in_red;
        result_next.out_green = pixel_reg.in_green;
        result_next.out_blue  = pixel_reg.in_blue;
        if (hit)
        begin
            result_next.out_alpha = alpha_value_reg;
        end
        else if (cfg_reg.mode_flags[ckas_pkg::MODE_HAS_ALPHA])
        begin
            result_next.out_alpha = pixel_reg.in_alpha;
        end
        else
        begin
            result_next.out_alpha = '0;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (stage_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // checks
    `CKAS_ASSERT_NEXT(a_take_fills_stage, take, stage_valid_reg)
    `CKAS_ASSERT_NEXT(a_stage_gives_done, stage_valid_reg, done_reg)
    `CKAS_ASSERT_NOW(a_no_alpha_source,
        done_reg && !cfg_reg.mode_flags[ckas_pkg::MODE_HAS_ALPHA],
        result_reg.out_alpha == alpha_value_reg || result_reg.out_alpha == 8'd0)

endmodule
